// ===== design/vdet_pkg.sv =====
// ----------------------------------------------------------------------------
// vdet_pkg
// Shared constants, codes and types for the vertex dedup / edge table block.
// ----------------------------------------------------------------------------
package vdet_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int EDGE_DEPTH   = 256;
  localparam int COORD_WIDTH  = 16;

  localparam int VIDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VCNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_W    = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int ECNT_W    = $clog2(EDGE_DEPTH + 1);
  localparam int FIELD_W   = 16;
  localparam int IDX_OUT_W = 8;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [FIELD_W-1:0]     field_t;

  localparam logic [REQ_W-1:0] REQ_ADD_VERTEX  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_EDGE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ_VERTEX = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_EDGE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VTX_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EDGE_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_RESOLVED,
    S_EDGE_WR,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    RES_NONE,
    RES_VTX_OK,
    RES_FULL_FIRST,
    RES_FULL_SECOND,
    RES_EDGE_FULL,
    RES_EDGE_OK,
    RES_RANGE,
    RES_READ_VTX,
    RES_READ_EDGE
  } res_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic take_hit;
    logic append;
    logic next_endpoint;
    logic edge_write;
    logic clear;
    logic finish;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic hit;
    logic scan_done;
    logic vtx_full;
    logic edge_full;
    logic vtx_idx_ok;
    logic edge_idx_ok;
    logic sel_second;
    logic out_free;
  } stat_t;

  function automatic coord_t coord_in(field_t v);
    return coord_t'(v);
  endfunction

  function automatic field_t coord_out(coord_t c);
    return field_t'(c);
  endfunction

endpackage

// ===== design/vertex_dedup_edge_table.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_edge_table
// Table of unique 2D vertices with an indexed edge list.
//
// Input channel (in_valid / in_stall) carries one request item: add vertex,
// add edge, clear, read vertex or read edge. Output channel (out_valid /
// out_stall) returns exactly one result item per request.
// One request is worked at a time; in_stall is low only while the sequencer
// is idle. The result sits in an output register, so the next item is taken
// while an earlier result still waits on out_stall.
// Add vertex and add edge take longer the more vertices are stored; the
// time is set by the vertex search: one stored vertex is compared per
// cycle, read from the vertex memory. After each result the sequencer
// returns to idle before the next item is taken.
// While out_stall is high a finished result holds the output register and
// the sequencer waits before handing over the next one.
// Reset (rst, synchronous) empties both tables at once; memory contents are
// not cleared and entries past the counts never reach a result.
// ----------------------------------------------------------------------------
module vertex_dedup_edge_table
  import vdet_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      req_type,
  input  field_t                first_x,
  input  field_t                first_y,
  input  field_t                second_x,
  input  field_t                second_y,
  input  logic [IDX_OUT_W-1:0]  read_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_OUT_W-1:0]  first_vertex_index,
  output logic [IDX_OUT_W-1:0]  second_vertex_index,
  output logic [IDX_OUT_W-1:0]  edge_index,
  output field_t                vertex_x_out,
  output field_t                vertex_y_out,
  output logic [STATUS_W-1:0]   status
);

  cmd_t  cmd;
  stat_t stat;

  vdet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vdet_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .req_type            (req_type),
    .first_x             (first_x),
    .first_y             (first_y),
    .second_x            (second_x),
    .second_y            (second_y),
    .read_index          (read_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .first_vertex_index  (first_vertex_index),
    .second_vertex_index (second_vertex_index),
    .edge_index          (edge_index),
    .vertex_x_out        (vertex_x_out),
    .vertex_y_out        (vertex_y_out),
    .status              (status)
  );

endmodule

// ===== design/vdet_ctrl.sv =====
// ----------------------------------------------------------------------------
// vdet_ctrl
// Request sequencer: dispatches each item and steps the datapath through
// the vertex searches, appends, edge write and result hand-off.
// ----------------------------------------------------------------------------
module vdet_ctrl
  import vdet_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  res_t   res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_NONE;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req)
          REQ_ADD_VERTEX: begin
            state_next = S_SCAN;
          end
          REQ_ADD_EDGE: begin
            if (stat.edge_full) begin
              res_next   = RES_EDGE_FULL;
              state_next = S_FINISH;
            end else begin
              state_next = S_SCAN;
            end
          end
          REQ_READ_VERTEX: begin
            res_next   = stat.vtx_idx_ok ? RES_READ_VTX : RES_RANGE;
            state_next = S_FINISH;
          end
          REQ_READ_EDGE: begin
            res_next   = stat.edge_idx_ok ? RES_READ_EDGE : RES_RANGE;
            state_next = S_FINISH;
          end
          default: begin
            res_next   = RES_NONE;
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_RESOLVED;
        end else if (stat.scan_done) begin
          if (stat.vtx_full) begin
            res_next   = stat.sel_second ? RES_FULL_SECOND : RES_FULL_FIRST;
            state_next = S_FINISH;
          end else begin
            state_next = S_RESOLVED;
          end
        end
      end
      S_RESOLVED: begin
        if (stat.req == REQ_ADD_VERTEX) begin
          res_next   = RES_VTX_OK;
          state_next = S_FINISH;
        end else if (!stat.sel_second) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_EDGE_WR;
        end
      end
      S_EDGE_WR: begin
        res_next   = RES_EDGE_OK;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res  = res;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        if (stat.req == REQ_ADD_VERTEX ||
            (stat.req == REQ_ADD_EDGE && !stat.edge_full)) begin
          cmd.scan_start = 1'b1;
        end
        if (stat.req == REQ_CLEAR) begin
          cmd.clear = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
        end else if (stat.scan_done && !stat.vtx_full) begin
          cmd.append = 1'b1;
        end
      end
      S_RESOLVED: begin
        if (stat.req != REQ_ADD_VERTEX && !stat.sel_second) begin
          cmd.next_endpoint = 1'b1;
          cmd.scan_start    = 1'b1;
        end
      end
      S_EDGE_WR: begin
        cmd.edge_write = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/vdet_dp.sv =====
// ----------------------------------------------------------------------------
// vdet_dp
// Datapath: request registers, vertex and edge memories, search pipeline,
// counts and the output register.
// ----------------------------------------------------------------------------
module vdet_dp
  import vdet_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [REQ_W-1:0]      req_type,
  input  field_t                first_x,
  input  field_t                first_y,
  input  field_t                second_x,
  input  field_t                second_y,
  input  logic [IDX_OUT_W-1:0]  read_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_OUT_W-1:0]  first_vertex_index,
  output logic [IDX_OUT_W-1:0]  second_vertex_index,
  output logic [IDX_OUT_W-1:0]  edge_index,
  output field_t                vertex_x_out,
  output field_t                vertex_y_out,
  output logic [STATUS_W-1:0]   status
);

  coord_t vx_mem [MAX_VERTICES];
  coord_t vy_mem [MAX_VERTICES];
  logic [VIDX_W-1:0] es_mem [EDGE_DEPTH];
  logic [VIDX_W-1:0] ee_mem [EDGE_DEPTH];

  logic [REQ_W-1:0]     req;
  coord_t               ax, ay, bx, by;
  logic [IDX_OUT_W-1:0] ridx;
  logic                 sel_second;

  logic [VCNT_W-1:0]    vcount;
  logic [ECNT_W-1:0]    ecount;
  logic [VCNT_W-1:0]    scan_addr;
  logic                 rd_valid;
  logic [VIDX_W-1:0]    rd_idx;
  coord_t               x_rd, y_rd;
  logic [VIDX_W-1:0]    es_rd, ee_rd;
  logic [VIDX_W-1:0]    i1, i2;
  logic [EIDX_W-1:0]    e_idx;

  coord_t               key_x, key_y;
  logic                 issue;
  logic [VIDX_W-1:0]    rd_addr;
  logic [EIDX_W-1:0]    erd_addr;

  assign key_x    = sel_second ? bx : ax;
  assign key_y    = sel_second ? by : ay;
  assign issue    = (scan_addr < vcount);
  assign rd_addr  = cmd.scan_step ? scan_addr[VIDX_W-1:0] : VIDX_W'(ridx);
  assign erd_addr = EIDX_W'(ridx);

  assign stat.req         = req;
  assign stat.hit         = rd_valid && (x_rd == key_x) && (y_rd == key_y);
  assign stat.scan_done   = !rd_valid && !issue;
  assign stat.vtx_full    = (vcount == VCNT_W'(MAX_VERTICES));
  assign stat.edge_full   = (ecount == ECNT_W'(EDGE_DEPTH));
  assign stat.vtx_idx_ok  = (VCNT_W'(ridx) < vcount);
  assign stat.edge_idx_ok = (ECNT_W'(ridx) < ecount);
  assign stat.sel_second  = sel_second;
  assign stat.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= '0;
      ecount    <= '0;
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        vcount <= '0;
        ecount <= '0;
      end
      if (cmd.append) begin
        vcount <= vcount + 1'b1;
      end
      if (cmd.edge_write) begin
        ecount <= ecount + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_addr <= '0;
        rd_valid  <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_valid <= issue;
        if (issue) begin
          scan_addr <= scan_addr + 1'b1;
        end
      end else begin
        rd_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req        <= req_type;
      ax         <= coord_in(first_x);
      ay         <= coord_in(first_y);
      bx         <= coord_in(second_x);
      by         <= coord_in(second_y);
      ridx       <= read_index;
      sel_second <= 1'b0;
    end else if (cmd.next_endpoint) begin
      sel_second <= 1'b1;
    end
    rd_idx <= scan_addr[VIDX_W-1:0];
    if (cmd.take_hit) begin
      if (sel_second) begin
        i2 <= rd_idx;
      end else begin
        i1 <= rd_idx;
      end
    end
    if (cmd.append) begin
      if (sel_second) begin
        i2 <= vcount[VIDX_W-1:0];
      end else begin
        i1 <= vcount[VIDX_W-1:0];
      end
    end
    if (cmd.edge_write) begin
      e_idx <= ecount[EIDX_W-1:0];
    end
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      vx_mem[vcount[VIDX_W-1:0]] <= key_x;
      vy_mem[vcount[VIDX_W-1:0]] <= key_y;
    end
    x_rd <= vx_mem[rd_addr];
    y_rd <= vy_mem[rd_addr];
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (cmd.edge_write) begin
      es_mem[ecount[EIDX_W-1:0]] <= i1;
      ee_mem[ecount[EIDX_W-1:0]] <= i2;
    end
    es_rd <= es_mem[erd_addr];
    ee_rd <= ee_mem[erd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      first_vertex_index  <= '0;
      second_vertex_index <= '0;
      edge_index          <= '0;
      vertex_x_out        <= '0;
      vertex_y_out        <= '0;
      status              <= ST_OK;
      case (cmd.res)
        RES_VTX_OK: begin
          first_vertex_index <= IDX_OUT_W'(i1);
        end
        RES_FULL_FIRST: begin
          status <= ST_VTX_FULL;
        end
        RES_FULL_SECOND: begin
          first_vertex_index <= IDX_OUT_W'(i1);
          status             <= ST_VTX_FULL;
        end
        RES_EDGE_FULL: begin
          status <= ST_EDGE_FULL;
        end
        RES_EDGE_OK: begin
          first_vertex_index  <= IDX_OUT_W'(i1);
          second_vertex_index <= IDX_OUT_W'(i2);
          edge_index          <= IDX_OUT_W'(e_idx);
        end
        RES_RANGE: begin
          status <= ST_RANGE;
        end
        RES_READ_VTX: begin
          vertex_x_out <= coord_out(x_rd);
          vertex_y_out <= coord_out(y_rd);
        end
        RES_READ_EDGE: begin
          first_vertex_index  <= IDX_OUT_W'(es_rd);
          second_vertex_index <= IDX_OUT_W'(ee_rd);
        end
        default: begin
          status <= ST_OK;
        end
      endcase
    end
  end

  a_vcount_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= VCNT_W'(MAX_VERTICES))
    else $error("vertex count above table size");

  a_ecount_bound: assert property (@(posedge clk) disable iff (rst)
    ecount <= ECNT_W'(EDGE_DEPTH))
    else $error("edge count above table size");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !stat.vtx_full)
    else $error("append into a full vertex table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (VCNT_W'(rd_idx) < vcount))
    else $error("search compared an entry past the count");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

endmodule
